@@ rtl/core/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the byte stream tokenizer
// Token kinds, scan modes and the event record passed from scanner to emitter.
// ----------------------------------------------------------------------------
package bst_pkg;

   localparam int OFF_W  = 20;
   localparam int LEN_W  = 21;
   localparam int LINE_W = 21;
   localparam int KIND_W = 5;

   localparam logic [KIND_W-1:0] K_DOT    = 5'd5;
   localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
   localparam logic [KIND_W-1:0] K_BANG   = 5'd11;
   localparam logic [KIND_W-1:0] K_EQ     = 5'd13;
   localparam logic [KIND_W-1:0] K_GT     = 5'd15;
   localparam logic [KIND_W-1:0] K_LT     = 5'd17;
   localparam logic [KIND_W-1:0] K_STRING = 5'd19;
   localparam logic [KIND_W-1:0] K_NUMBER = 5'd20;
   localparam logic [KIND_W-1:0] K_IDENT  = 5'd21;
   localparam logic [KIND_W-1:0] K_KW0    = 5'd22;
   localparam logic [KIND_W-1:0] K_EOF    = 5'd26;
   localparam logic [KIND_W-1:0] K_EBAD   = 5'd27;
   localparam logic [KIND_W-1:0] K_ESTR   = 5'd28;
   localparam logic [KIND_W-1:0] K_EBLK   = 5'd29;

   localparam logic [LINE_W-1:0] LINE_CAP = 21'd1048576;

   typedef enum logic [3:0] {
      M_IDLE, M_PEND, M_LINE, M_BLOCK, M_STR, M_INT, M_DOT, M_FRAC, M_IDENT
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFF_W-1:0]  start;
      logic [LEN_W-1:0]  len;
      logic [LINE_W-1:0] line;
      logic [7:0]        bad;
      logic              last;
   } tok_type;

   // up to four results per request
   typedef struct packed {
      logic [2:0]   count;
      tok_type [3:0] tok;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] b);
      // bit 5 set: not a single-character operator
      case (b)
         8'h28: return 6'd0;
         8'h29: return 6'd1;
         8'h7B: return 6'd2;
         8'h7D: return 6'd3;
         8'h2C: return 6'd4;
         8'h2E: return 6'd5;
         8'h2D: return 6'd6;
         8'h2B: return 6'd7;
         8'h3B: return 6'd8;
         8'h2A: return 6'd10;
         default: return 6'h20;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pend_kind(input logic [7:0] p);
      case (p)
         8'h21: return K_BANG;
         8'h3D: return K_EQ;
         8'h3E: return K_GT;
         8'h3C: return K_LT;
         default: return K_SLASH;
      endcase
   endfunction

   // keyword character at a position: and, var, nil, print
   function automatic logic [7:0] kw_char(input logic [1:0] j, input logic [2:0] pos);
      logic [39:0] s;
      case (j)
         2'd0: s = {"and", 16'h0};
         2'd1: s = {"var", 16'h0};
         2'd2: s = {"nil", 16'h0};
         default: s = "print";
      endcase
      return s[39 - 8*pos -: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] j);
      return (j == 2'd3) ? 3'd5 : 3'd3;
   endfunction

endpackage

@@ rtl/core/byte_stream_tokenizer.sv @@
// ----------------------------------------------------------------------------
// byte_stream_tokenizer: streaming lexical scanner
// Source bytes in, tokens out as kind, offset, length and line.
// ----------------------------------------------------------------------------
// Usage: present one request per cycle on req_* (a byte, a has-byte flag and
// an end-of-source flag). Each request yields zero to four tokens on rsp_*,
// one per cycle while rsp_stall is low; rsp_last_of_run marks its last token.
// The scanner takes a request every cycle while its output register is free;
// the two-bundle queue in the emitter absorbs short stalls. A request that
// yields k tokens holds the emitter until all k are sent, so sustained rate is
// one request per cycle for up to one token per request with rsp_stall low.
// The first token of a request goes through the scanner output register and
// then the emitter queue before it is offered on rsp_*.
// Reset returns the scan state to idle, offset 0, line 1, and empties the
// queue. While rsp_stall is high tokens hold, the queue fills, and then
// req_stall rises.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer
   import bst_pkg::*;
#(
   parameter longint MAX_SOURCE_BYTES = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [19:0] rsp_start_offset,
   output logic [20:0] rsp_lexeme_length,
   output logic [20:0] rsp_line_number,
   output logic [7:0]  rsp_bad_byte,
   output logic        rsp_last_of_run
);

   logic       mid_valid, mid_stall;
   bundle_type mid_bundle;
   tok_type    tok;

   bst_scan #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_scan (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall),
      .data_byte(req_data_byte), .has_byte(req_has_byte),
      .end_of_source(req_end_of_source),
      .out_valid(mid_valid), .out_stall(mid_stall), .out_bundle(mid_bundle)
   );

   bst_emit u_emit (
      .clock(clock), .reset(reset),
      .in_valid(mid_valid), .in_stall(mid_stall), .in_bundle(mid_bundle),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_tok(tok)
   );

   assign rsp_kind          = tok.kind;
   assign rsp_start_offset  = tok.start;
   assign rsp_lexeme_length = tok.len;
   assign rsp_line_number   = tok.line;
   assign rsp_bad_byte      = tok.bad;
   assign rsp_last_of_run   = tok.last;

endmodule

@@ rtl/core/bst_scan.sv @@
// ----------------------------------------------------------------------------
// bst_scan: front end of the tokenizer
// Accepts one request per cycle unless in_stall is high, steps the scan state
// and produces the bundle of tokens that the request completes.
// ----------------------------------------------------------------------------
module bst_scan
   import bst_pkg::*;
#(
   parameter longint MAX_SOURCE_BYTES = 1048576
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  logic [7:0] data_byte,
   input  logic       has_byte,
   input  logic       end_of_source,
   output logic       out_valid,
   input  logic       out_stall,
   output bundle_type out_bundle
);

   localparam int CW = $clog2(MAX_SOURCE_BYTES + 1);
   localparam logic [CW-1:0] OFF_CAP = CW'(MAX_SOURCE_BYTES);
   localparam logic [CW-1:0] CLAMP_LIM =
      (MAX_SOURCE_BYTES - 1 > 1048575) ? CW'(1048575) : CW'(MAX_SOURCE_BYTES - 1);

   mode_type         mode_ff, mode_in;
   logic [CW-1:0]    start_ff, start_in, off_ff, off_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [7:0]       pend_ff, pend_in;
   logic [3:0]       cand_ff, cand_in;
   logic [1:0]       utf_ff, utf_in;
   logic             ovalid_ff;
   bundle_type       bundle_ff, bundle_in;
   logic             take;

   assign in_stall   = ovalid_ff && out_stall;
   assign take       = in_valid && !in_stall;
   assign out_valid  = ovalid_ff;
   assign out_bundle = bundle_ff;

   function automatic logic [OFF_W-1:0] cap_off(input logic [CW:0] x);
      return (x > (CW+1)'(1048575)) ? OFF_W'(1048575) : OFF_W'(x);
   endfunction

   function automatic logic [LEN_W-1:0] cap_len(input logic [CW:0] x);
      return (x > (CW+1)'(2097151)) ? LEN_W'(2097151) : LEN_W'(x);
   endfunction

   always_comb begin
      logic [CW:0]   span, span1;
      logic [5:0]    sk;
      logic [2:0]    n;
      logic          do_idle;
      logic [7:0]    b;
      logic [KIND_W-1:0] ik;
      logic [CW-1:0] clamp_cur, dot_off;
      mode_type      fm;
      logic [CW-1:0] fstart, foff;
      logic [LINE_W-1:0] fline;
      logic [7:0]    fpend;
      logic [3:0]    fcand;

      mode_in  = mode_ff;
      start_in = start_ff;
      off_in   = off_ff;
      line_in  = line_ff;
      pend_in  = pend_ff;
      cand_in  = cand_ff;
      utf_in   = utf_ff;
      bundle_in = '0;
      n = 3'd0;
      do_idle = 1'b0;
      b = data_byte;
      ik = K_IDENT;
      fm = mode_ff; fstart = start_ff; foff = off_ff; fline = line_ff;
      fpend = pend_ff; fcand = cand_ff;

      span  = (off_ff > start_ff) ? {1'b0, off_ff - start_ff} : '0;
      span1 = ({1'b0, off_ff} + 1'b1 > {1'b0, start_ff}) ?
              ({1'b0, off_ff} + 1'b1 - {1'b0, start_ff}) : '0;
      clamp_cur = (off_ff > CLAMP_LIM) ? CLAMP_LIM : off_ff;
      dot_off   = (off_ff > 0) ? off_ff - 1'b1 : '0;
      dot_off   = (dot_off > CLAMP_LIM) ? CLAMP_LIM : dot_off;
      for (int j = 0; j < 4; j++)
         if (cand_ff[j] && span == (CW+1)'(kw_len(2'(j)))) ik = K_KW0 + KIND_W'(j);
      sk = single_kind(b);

      if (has_byte) begin
         unique case (mode_ff) inside
            M_PEND: begin
               pend_in = '0;
               if (pend_ff == 8'h2F && b == 8'h2F) mode_in = M_LINE;
               else if (pend_ff == 8'h2F && b == 8'h2A) mode_in = M_BLOCK;
               else if (pend_ff != 8'h2F && b == 8'h3D) begin
                  bundle_in.tok[0] = '{pend_kind(pend_ff) + 1'b1, cap_off({1'b0, start_ff}),
                                       LEN_W'(2), line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  mode_in = M_IDLE;
               end else begin
                  bundle_in.tok[0] = '{pend_kind(pend_ff), cap_off({1'b0, start_ff}),
                                       LEN_W'(1), line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_LINE: begin
               if (b == 8'h0A) begin
                  if (line_ff < LINE_CAP) line_in = line_ff + 1'b1;
                  mode_in = M_IDLE;
               end
            end
            M_BLOCK: begin
               if (pend_ff == 8'h2A && b == 8'h2F) begin
                  pend_in = '0;
                  mode_in = M_IDLE;
               end else pend_in = (b == 8'h2A) ? 8'h2A : 8'h00;
            end
            M_STR: begin
               if (utf_ff != 2'd0) utf_in = utf_ff - 1'b1;
               else if (b == 8'h22) begin
                  bundle_in.tok[0] = '{K_STRING, cap_off({1'b0, start_ff}), cap_len(span1),
                                       line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  mode_in = M_IDLE;
               end else if (b == 8'h0A) begin
                  if (line_ff < LINE_CAP) line_in = line_ff + 1'b1;
               end else if (b < 8'h80) begin
                  utf_in = utf_ff;
               end else if ((b & 8'hE0) == 8'hC0) utf_in = 2'd1;
               else if ((b & 8'hF0) == 8'hE0) utf_in = 2'd2;
               else if ((b & 8'hF8) == 8'hF0) utf_in = 2'd3;
               else begin
                  bundle_in.tok[0] = '{K_ESTR, cap_off({1'b0, start_ff}), cap_len(span1),
                                       line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  mode_in = M_IDLE;
               end
            end
            M_INT, M_FRAC: begin
               if (is_digit(b)) mode_in = mode_ff;
               else if (mode_ff == M_INT && b == 8'h2E) mode_in = M_DOT;
               else begin
                  bundle_in.tok[0] = '{K_NUMBER, cap_off({1'b0, start_ff}), cap_len(span),
                                       line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(b)) mode_in = M_FRAC;
               else begin
                  bundle_in.tok[0] = '{K_NUMBER, cap_off({1'b0, start_ff}),
                                       cap_len((span > 0) ? span - 1'b1 : span),
                                       line_ff, 8'h0, 1'b0};
                  bundle_in.tok[1] = '{K_DOT, cap_off({1'b0, dot_off}), LEN_W'(1),
                                       line_ff, 8'h0, 1'b0};
                  n = 3'd2;
                  do_idle = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_digit(b) || is_alpha(b)) begin
                  for (int j = 0; j < 4; j++)
                     if (off_ff >= OFF_CAP || span >= (CW+1)'(kw_len(2'(j))) ||
                         kw_char(2'(j), 3'(span)) != b)
                        cand_in[j] = 1'b0;
               end else begin
                  bundle_in.tok[0] = '{ik, cap_off({1'b0, start_ff}), cap_len(span),
                                       line_ff, 8'h0, 1'b0};
                  n = 3'd1;
                  do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            mode_in  = M_IDLE;
            start_in = clamp_cur;
            if (!sk[5]) begin
               bundle_in.tok[n[1:0]] = '{sk[4:0], cap_off({1'b0, clamp_cur}), LEN_W'(1),
                                         line_ff, 8'h0, 1'b0};
               n = n + 1'b1;
            end else if (b == 8'h21 || b == 8'h3D || b == 8'h3C || b == 8'h3E ||
                         b == 8'h2F) begin
               mode_in = M_PEND;
               pend_in = b;
            end else if (b == 8'h20 || b == 8'h0D || b == 8'h09) begin
               mode_in = M_IDLE;
            end else if (b == 8'h0A) begin
               if (line_ff < LINE_CAP) line_in = line_ff + 1'b1;
            end else if (b == 8'h22) begin
               mode_in = M_STR;
               utf_in  = '0;
            end else if (is_digit(b)) mode_in = M_INT;
            else if (is_alpha(b)) begin
               mode_in = M_IDENT;
               for (int j = 0; j < 4; j++) cand_in[j] = (kw_char(2'(j), 3'd0) == b);
            end else begin
               bundle_in.tok[n[1:0]] = '{K_EBAD, cap_off({1'b0, clamp_cur}), LEN_W'(1),
                                         line_ff, b, 1'b0};
               n = n + 1'b1;
            end
         end
         if (off_ff < OFF_CAP) off_in = off_ff + 1'b1;
      end

      if (end_of_source) begin
         fm = mode_in; fstart = start_in; foff = off_in; fline = line_in;
         fpend = pend_in; fcand = cand_in;
         span  = (foff > fstart) ? {1'b0, foff - fstart} : '0;
         clamp_cur = (foff > CLAMP_LIM) ? CLAMP_LIM : foff;
         dot_off = (foff > 0) ? foff - 1'b1 : '0;
         dot_off = (dot_off > CLAMP_LIM) ? CLAMP_LIM : dot_off;
         ik = K_IDENT;
         for (int j = 0; j < 4; j++)
            if (fcand[j] && span == (CW+1)'(kw_len(2'(j)))) ik = K_KW0 + KIND_W'(j);
         unique case (fm) inside
            M_PEND: begin
               bundle_in.tok[n[1:0]] = '{pend_kind(fpend), cap_off({1'b0, fstart}),
                                         LEN_W'(1), fline, 8'h0, 1'b0};
               n = n + 1'b1;
            end
            M_BLOCK, M_STR: begin
               bundle_in.tok[n[1:0]] = '{(fm == M_BLOCK) ? K_EBLK : K_ESTR,
                                         cap_off({1'b0, fstart}), cap_len(span),
                                         fline, 8'h0, 1'b0};
               n = n + 1'b1;
            end
            M_INT, M_FRAC, M_IDENT: begin
               bundle_in.tok[n[1:0]] = '{(fm == M_IDENT) ? ik : K_NUMBER,
                                         cap_off({1'b0, fstart}), cap_len(span),
                                         fline, 8'h0, 1'b0};
               n = n + 1'b1;
            end
            M_DOT: begin
               bundle_in.tok[n[1:0]] = '{K_NUMBER, cap_off({1'b0, fstart}),
                                         cap_len((span > 0) ? span - 1'b1 : span),
                                         fline, 8'h0, 1'b0};
               n = n + 1'b1;
               bundle_in.tok[n[1:0]] = '{K_DOT, cap_off({1'b0, dot_off}), LEN_W'(1),
                                         fline, 8'h0, 1'b0};
               n = n + 1'b1;
            end
            default: n = n;
         endcase
         if (n < 3'd4) begin
            bundle_in.tok[n[1:0]] = '{K_EOF, cap_off({1'b0, clamp_cur}), LEN_W'(0),
                                      fline, 8'h0, 1'b0};
            n = n + 1'b1;
         end
         mode_in = M_IDLE; start_in = '0; off_in = '0; line_in = LINE_W'(1);
         pend_in = '0; cand_in = '0; utf_in = '0;
      end
      if (n != 3'd0) bundle_in.tok[n[1:0] - 2'd1].last = 1'b1;
      bundle_in.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         start_ff  <= '0;
         off_ff    <= '0;
         line_ff   <= LINE_W'(1);
         pend_ff   <= '0;
         cand_ff   <= '0;
         utf_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            off_ff   <= off_in;
            line_ff  <= line_in;
            pend_ff  <= pend_in;
            cand_ff  <= cand_in;
            utf_ff   <= utf_in;
         end
         if (!in_stall) ovalid_ff <= take && (bundle_in.count != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (take) bundle_ff <= bundle_in;
   end

endmodule

@@ rtl/core/bst_emit.sv @@
// ----------------------------------------------------------------------------
// bst_emit: back end of the tokenizer
// Queues scanner bundles, sends their tokens one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bst_emit
   import bst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  bundle_type in_bundle,
   output logic       out_valid,
   input  logic       out_stall,
   output tok_type    out_tok
);

   bundle_type  q_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic [1:0]  idx_ff;
   logic        push, pop, send;
   bundle_type  head;

   assign head      = q_ff[rp_ff];
   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_tok   = head.tok[idx_ff];
   assign send      = out_valid && !out_stall;
   // drop the bundle after its last token goes out
   assign pop       = send && ({1'b0, idx_ff} + 3'd1 == head.count);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) begin
            rp_ff  <= !rp_ff;
            idx_ff <= '0;
         end else if (send) idx_ff <= idx_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_bundle;
   end

endmodule
